// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REQ_PUSH_REAR  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_LIST       = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

endpackage

// ===== sv/dq_addr.sv =====
// ----------------------------------------------------------------------------
// dq_addr
// Shared ring index unit: base plus offset, wrapped modulo the depth.
// ----------------------------------------------------------------------------
module dq_addr (
  input  logic [dq_pkg::IDX_W-1:0] base_i,
  input  logic [dq_pkg::IDX_W-1:0] offset_i,
  output logic [dq_pkg::IDX_W-1:0] slot_o
);

  localparam logic [dq_pkg::IDX_W:0] DepthL = (dq_pkg::IDX_W + 1)'(dq_pkg::DEPTH);

  logic [dq_pkg::IDX_W:0] sum;
  logic [dq_pkg::IDX_W:0] wrapped;

  assign sum     = {1'b0, base_i} + {1'b0, offset_i};
  assign wrapped = sum - DepthL;
  assign slot_o  = (sum >= DepthL) ? wrapped[dq_pkg::IDX_W-1:0] : sum[dq_pkg::IDX_W-1:0];

endmodule

// ===== sv/dq_store.sv =====
// ----------------------------------------------------------------------------
// dq_store
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_store (
  input  logic                      clk_i,
  input  dq_pkg::store_req_t        req_i,
  output logic [dq_pkg::DATA_W-1:0] rdata_o
);

  logic [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit values with push/pop at both ends and
// a front-to-rear listing.
// ----------------------------------------------------------------------------
// One request is handled at a time; s_axis_tready is high only while the
// block is idle. A push, or any request answered with empty or full, goes
// from accept straight to S_SEND, which holds the result word, then the
// block is idle again once the word is taken. A pop passes through S_READ
// for the storage read before S_SEND. A list request streams its entries
// one word at a time, through S_READ and then S_SEND for each word, as set
// by the single read port of the entry storage and its registered read
// data; storage slot addresses go through one shared modulo adder. Request
// codes five to seven are accepted and dropped without a result.
module double_ended_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,   // [31:0] push_value
  input  logic [2:0]                s_axis_tuser,   // [2:0] req_type
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,   // [31:0] out_value
  output logic [1:0]                m_axis_tuser,   // [1:0] status
  output logic                      m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [dq_pkg::IDX_W-1:0]  head_q, head_d;
  logic [dq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [dq_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic                      list_q, list_d;
  logic [1:0]                stat_q, stat_d;
  logic [dq_pkg::DATA_W-1:0] val_q, val_d;
  logic                      last_q, last_d;

  logic [dq_pkg::IDX_W-1:0]  au_off;
  logic [dq_pkg::IDX_W-1:0]  au_slot;
  logic [dq_pkg::CNT_W-1:0]  cnt_m1;
  logic [dq_pkg::IDX_W-1:0]  idx_nx;
  logic                      full;
  logic                      empty;
  logic                      in_acc;
  logic [dq_pkg::DATA_W-1:0] rd_data;
  dq_pkg::store_req_t        st_req;

  dq_addr u_addr (
    .base_i  (head_q),
    .offset_i(au_off),
    .slot_o  (au_slot)
  );

  dq_store u_store (
    .clk_i  (clk_i),
    .req_i  (st_req),
    .rdata_o(rd_data)
  );

  assign full          = (cnt_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty         = (cnt_q == '0);
  assign cnt_m1        = cnt_q - dq_pkg::CNT_W'(1);
  assign idx_nx        = idx_q + dq_pkg::IDX_W'(1);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    list_d  = list_q;
    stat_d  = stat_q;
    val_d   = val_q;
    last_d  = last_q;
    au_off  = '0;
    st_req  = '0;
    st_req.wdata = s_axis_tdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          stat_d = dq_pkg::STAT_OK;
          val_d  = '0;
          last_d = 1'b1;
          list_d = 1'b0;
          unique case (s_axis_tuser)
            dq_pkg::REQ_PUSH_REAR: begin
              state_d = S_SEND;
              au_off  = cnt_q[dq_pkg::IDX_W-1:0];
              if (full) begin
                stat_d = dq_pkg::STAT_FULL;
              end else begin
                st_req.wr_en = 1'b1;
                st_req.waddr = au_slot;
                cnt_d        = cnt_q + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::REQ_PUSH_FRONT: begin
              state_d = S_SEND;
              au_off  = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
              if (full) begin
                stat_d = dq_pkg::STAT_FULL;
              end else begin
                st_req.wr_en = 1'b1;
                st_req.waddr = au_slot;
                head_d       = au_slot;
                cnt_d        = cnt_q + dq_pkg::CNT_W'(1);
              end
            end
            dq_pkg::REQ_POP_FRONT: begin
              au_off = dq_pkg::IDX_W'(1);
              if (empty) begin
                stat_d  = dq_pkg::STAT_EMPTY;
                state_d = S_SEND;
              end else begin
                st_req.rd_en = 1'b1;
                st_req.raddr = head_q;
                head_d       = au_slot;
                cnt_d        = cnt_m1;
                state_d      = S_READ;
              end
            end
            dq_pkg::REQ_POP_REAR: begin
              au_off = cnt_m1[dq_pkg::IDX_W-1:0];
              if (empty) begin
                stat_d  = dq_pkg::STAT_EMPTY;
                state_d = S_SEND;
              end else begin
                st_req.rd_en = 1'b1;
                st_req.raddr = au_slot;
                cnt_d        = cnt_m1;
                state_d      = S_READ;
              end
            end
            dq_pkg::REQ_LIST: begin
              if (empty) begin
                stat_d  = dq_pkg::STAT_EMPTY;
                state_d = S_SEND;
              end else begin
                st_req.rd_en = 1'b1;
                st_req.raddr = head_q;
                idx_d        = '0;
                list_d       = 1'b1;
                state_d      = S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        val_d   = rd_data;
        stat_d  = dq_pkg::STAT_OK;
        last_d  = list_q ? (dq_pkg::CNT_W'(idx_q) + dq_pkg::CNT_W'(1) == cnt_q) : 1'b1;
        state_d = S_SEND;
      end
      S_SEND: begin
        au_off = idx_nx;
        if (m_axis_tready) begin
          if (list_q && !last_q) begin
            st_req.rd_en = 1'b1;
            st_req.raddr = au_slot;
            idx_d        = idx_nx;
            state_d      = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      list_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      list_q  <= list_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = (state_q == S_SEND);
  assign m_axis_tdata  = val_q;
  assign m_axis_tuser  = stat_q;
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("entry count above depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a result word is pending");

  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> $past(st_req.rd_en))
    else $error("read state entered without a storage read");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != dq_pkg::STAT_OK) |-> (m_axis_tdata == '0 && m_axis_tlast))
    else $error("empty or full report carries data or is not last");
`endif

endmodule
